FILE: sv/mrrc_pkg.sv
package mrrc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 8;

  localparam logic [15:0] CRC_SEED        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE        = 8'h06;
  localparam logic [7:0]  FC_EXC_BIT      = 8'h80;
  localparam logic [7:0]  READ_DATA_BYTES = 8'h02;
  localparam int unsigned READ_MIN_LEN    = 7;
  localparam int unsigned WRITE_MIN_LEN   = 8;
  localparam int unsigned HEAD_DEPTH      = 6;
  localparam logic [7:0]  SLAVE_ADDR_RST  = 8'd33;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_ADDRESS   = 4'd2,
    ST_EXCEPTION = 4'd3,
    ST_FUNCTION  = 4'd4,
    ST_BYTECOUNT = 4'd5,
    ST_CRC       = 4'd6,
    ST_REGISTER  = 4'd7,
    ST_VALUE     = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        cmd;
    logic [15:0] expect_register;
    logic [15:0] expect_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] read_value;
    logic [7:0]  exception_code;
  } out_item_t;

  // one byte through the reflected CRC-16, unrolled
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/modbus_rtu_response_checker_top.sv
// Modbus RTU reply checker. Takes one reply byte per transfer on the in_
// channel, one every cycle while in_ready is high, and on the byte flagged
// frame_end gives one result (status, read value, exception code) on the
// out_ channel; other bytes give no result. The CRC-16 (reflected 0xA001,
// seed 0xFFFF) runs two bytes behind the stream, one unrolled update per
// byte, so the two trailing CRC bytes are compared against it. A two-entry
// registered output buffer lets input continue while results wait; in_ready
// drops only when two results are pending. cmd and the expected register and
// value are sampled on the last byte only. The expected slave address is
// written through cfg_ at any time the block is idle; cfg_ready is always high.
module modbus_rtu_response_checker_top #(
  parameter int unsigned COUNT_WIDTH = mrrc_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrrc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrrc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import mrrc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [7:0]             slave_addr_r;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [15:0]            crc_r, crc_nxt, crc_fed;
  logic [7:0]             d0_r, d0_nxt, d1_r, d1_nxt;
  logic [7:0]             head_r [HEAD_DEPTH];
  logic [7:0]             head_nxt [HEAD_DEPTH];
  logic [7:0]             head_upd [HEAD_DEPTH];

  logic      in_fire, res_valid, out_take;
  out_item_t res;
  logic      out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  out_item_t out_r, out_nxt, skid_r, skid_nxt;

  logic [7:0]  fc;
  logic [15:0] rx_crc_word, reg_echo, val_echo;
  logic        too_short;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign res_valid = in_fire & in_data.frame_end;
  assign out_take  = out_valid_r & out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // frame state update for the incoming byte
  always_comb begin
    crc_fed = (cnt_r >= COUNT_WIDTH'(2)) ? crc_feed(crc_r, d0_r) : crc_r;
    cnt_inc = (cnt_r != CNT_MAX) ? cnt_r + COUNT_WIDTH'(1) : cnt_r;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_upd[i] = (cnt_r == COUNT_WIDTH'(i)) ? in_data.rx_byte : head_r[i];
    end
  end

  // frame check
  always_comb begin
    fc          = in_data.cmd ? FC_WRITE : FC_READ;
    rx_crc_word = {in_data.rx_byte, d1_r};
    reg_echo    = {head_upd[2], head_upd[3]};
    val_echo    = {head_upd[4], head_upd[5]};
    too_short = in_data.cmd ? (cnt_inc < COUNT_WIDTH'(WRITE_MIN_LEN))
                            : (cnt_inc < COUNT_WIDTH'(READ_MIN_LEN));
    res = '0;
    if (too_short) begin
      res.status = ST_SHORT;
    end else if (head_upd[0] != slave_addr_r) begin
      res.status = ST_ADDRESS;
    end else if (head_upd[1] == (fc | FC_EXC_BIT)) begin
      res.status         = ST_EXCEPTION;
      res.exception_code = head_upd[2];
    end else if (head_upd[1] != fc) begin
      res.status = ST_FUNCTION;
    end else if (!in_data.cmd) begin
      if (head_upd[2] != READ_DATA_BYTES) begin
        res.status = ST_BYTECOUNT;
      end else if (rx_crc_word != crc_fed) begin
        res.status = ST_CRC;
      end else begin
        res.read_value = {head_upd[3], head_upd[4]};
      end
    end else begin
      if (rx_crc_word != crc_fed) begin
        res.status = ST_CRC;
      end else if (reg_echo != in_data.expect_register) begin
        res.status = ST_REGISTER;
      end else if (val_echo != in_data.expect_value) begin
        res.status = ST_VALUE;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    head_nxt = head_r;
    if (in_fire) begin
      if (in_data.frame_end) begin
        cnt_nxt = '0;
        crc_nxt = CRC_SEED;
        d0_nxt  = '0;
        d1_nxt  = '0;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
          head_nxt[i] = '0;
        end
      end else begin
        cnt_nxt  = cnt_inc;
        crc_nxt  = crc_fed;
        d0_nxt   = d1_r;
        d1_nxt   = in_data.rx_byte;
        head_nxt = head_upd;
      end
    end
  end

  // two-entry result buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
      cnt_r        <= '0;
      crc_r        <= CRC_SEED;
      d0_r         <= '0;
      d1_r         <= '0;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head_r[i] <= '0;
      end
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slave_addr_r <= cfg_data;
      end
      cnt_r        <= cnt_nxt;
      crc_r        <= crc_nxt;
      d0_r         <= d0_nxt;
      d1_r         <= d1_nxt;
      head_r       <= head_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("no result after last byte of frame");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (cnt_r == '0) && (crc_r == CRC_SEED))
    else $error("frame state not cleared after last byte");

  a_read_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status != ST_OK) |-> out_r.read_value == '0)
    else $error("read value on failed reply");

endmodule

FILE: dv/mrrc_reply_checker.sv
module mrrc_reply_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mrrc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mrrc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int unsigned         mismatches,
  output int unsigned         replies_due_cnt,
  output int unsigned         replies_checked,
  output logic [8:0]          status_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import mrrc_pkg::*;

  localparam int unsigned TALLY_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  logic [7:0]  addr_q;
  int unsigned tally;
  logic [15:0] crc_acc;
  logic [7:0]  lag [2];
  logic [7:0]  head [HEAD_DEPTH];
  out_item_t   replies_due [$];
  int unsigned errs = 0;
  int unsigned n_checked = 0;
  logic [8:0]  seen = '0;

  // bit-serial form of the reflected CRC-16
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ ((r[0] ^ b[i]) ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    tally   = 0;
    crc_acc = CRC_SEED;
    lag[0]  = '0;
    lag[1]  = '0;
    foreach (head[i]) head[i] = '0;
  endfunction

  // CRC trails the stream by two bytes so the trailing CRC never enters it
  task automatic absorb_byte(input in_item_t it);
    out_item_t   r;
    logic [7:0]  fc;
    logic [15:0] rx_crc;
    int unsigned need;
    status_t     st;
    if (tally >= 2) crc_acc = crc16_step(crc_acc, lag[0]);
    lag[0] = lag[1];
    lag[1] = it.rx_byte;
    if (tally < HEAD_DEPTH) head[tally] = it.rx_byte;
    if (tally < TALLY_MAX) tally++;
    if (!it.frame_end) return;

    r      = '0;
    fc     = it.cmd ? FC_WRITE : FC_READ;
    need   = it.cmd ? WRITE_MIN_LEN : READ_MIN_LEN;
    rx_crc = {lag[1], lag[0]};
    st     = ST_OK;
    if (tally < need) begin
      st = ST_SHORT;
    end else if (head[0] != addr_q) begin
      st = ST_ADDRESS;
    end else if (head[1] == (fc | FC_EXC_BIT)) begin
      st = ST_EXCEPTION;
      r.exception_code = head[2];
    end else if (head[1] != fc) begin
      st = ST_FUNCTION;
    end else if (!it.cmd) begin
      if (head[2] != READ_DATA_BYTES) begin
        st = ST_BYTECOUNT;
      end else if (rx_crc != crc_acc) begin
        st = ST_CRC;
      end else begin
        r.read_value = {head[3], head[4]};
      end
    end else if (rx_crc != crc_acc) begin
      st = ST_CRC;
    end else if ({head[2], head[3]} != it.expect_register) begin
      st = ST_REGISTER;
    end else if ({head[4], head[5]} != it.expect_value) begin
      st = ST_VALUE;
    end
    r.status = st;
    // newest at the front, oldest taken from the back
    replies_due.push_front(r);
    clear_frame();
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      addr_q = SLAVE_ADDR_RST;
      clear_frame();
      replies_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("%0t: unexpected reply: status %0d value %h exc %h", $realtime,
                     out_data.status, out_data.read_value, out_data.exception_code);
          end
        end else begin
          want = replies_due.pop_back();
          n_checked++;
          seen[want.status] = 1'b1;
          if (out_data.status !== want.status || out_data.read_value !== want.read_value ||
              out_data.exception_code !== want.exception_code) begin
            errs++;
            if (errs <= 10) begin
              $display("%0t: mismatch: expected status %0d value %h exc %h, got %0d %h %h",
                       $realtime, want.status, want.read_value, want.exception_code,
                       out_data.status, out_data.read_value, out_data.exception_code);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) addr_q = cfg_data;
      if (in_valid && in_ready) absorb_byte(in_data);
    end
    mismatches      <= errs;
    replies_due_cnt <= replies_due.size();
    replies_checked <= n_checked;
    status_seen     <= seen;
  end

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrrc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_BYTES = 145;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int unsigned mismatches;
  int unsigned due_cnt;
  int unsigned checked;
  logic [8:0]  seen;

  logic [7:0]  cur_addr;
  logic [7:0]  frame_q [$];
  logic [7:0]  addr_plan [6];
  bit          quiet;
  bit          hold_go;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned settings_used;
  int unsigned stalled_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  modbus_rtu_response_checker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mrrc_reply_checker reply_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .replies_due_cnt (due_cnt),
    .replies_checked (checked),
    .status_seen     (seen)
  );

  task automatic offer_byte(input in_item_t it);
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic append_byte(input logic [7:0] v);
    frame_q.insert(frame_q.size(), v);
  endtask

  // request fields only count on the last byte, so the others carry noise
  task automatic send_frame(input logic cmd, input logic [15:0] ereg, input logic [15:0] eval);
    in_item_t it;
    foreach (frame_q[i]) begin
      it.rx_byte   = frame_q[i];
      it.frame_end = (i == frame_q.size() - 1);
      if (it.frame_end) begin
        it.cmd             = cmd;
        it.expect_register = ereg;
        it.expect_value    = eval;
      end else begin
        it.cmd             = 1'($urandom_range(1, 0));
        it.expect_register = 16'($urandom_range(65535));
        it.expect_value    = 16'($urandom_range(65535));
      end
      offer_byte(it);
    end
    frames_sent++;
  endtask

  task automatic seal_crc();
    logic [15:0] c;
    c = CRC_SEED;
    foreach (frame_q[i]) c = crc_feed(c, frame_q[i]);
    append_byte(c[7:0]);
    append_byte(c[15:8]);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) append_byte(8'($urandom_range(255)));
  endtask

  task automatic set_slave_addr(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_addr = v;
    settings_used++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_cnt != 0);
    repeat (4) @(posedge clk);
  endtask

  // pad_long forces a well-formed reply stretched by that many data bytes
  task automatic random_frame(input int unsigned pad_long);
    int unsigned kind;
    int unsigned idx;
    logic        cmd;
    logic [15:0] reg_w, val_w, ereg, eval;
    logic [7:0]  a, fc;
    kind  = (pad_long != 0) ? 40 : $urandom_range(99);
    cmd   = 1'($urandom_range(1, 0));
    reg_w = 16'($urandom_range(65535));
    val_w = 16'($urandom_range(65535));
    ereg  = reg_w;
    eval  = val_w;
    fc    = cmd ? FC_WRITE : FC_READ;
    a     = cur_addr;
    frame_q.delete();
    if (kind >= 58 && kind < 64) a = cur_addr ^ 8'($urandom_range(255, 1));
    if (kind < 64) begin
      append_byte(a);
      append_byte(fc);
      if (cmd) begin
        append_byte(reg_w[15:8]);
        append_byte(reg_w[7:0]);
      end else begin
        append_byte(READ_DATA_BYTES);
      end
      append_byte(val_w[15:8]);
      append_byte(val_w[7:0]);
      if (kind >= 40 && kind < 46) begin
        push_random(pad_long != 0 ? pad_long : $urandom_range(30, 1));
      end
      seal_crc();
      if (kind >= 46 && kind < 54) begin
        idx = $urandom_range(frame_q.size() - 1, 2);
        frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(7));
      end
      if (kind >= 54 && kind < 58) begin
        if (kind[0]) ereg = ereg ^ 16'($urandom_range(65535, 1));
        else         eval = eval ^ 16'($urandom_range(65535, 1));
      end
    end else if (kind < 70) begin
      append_byte(cur_addr);
      append_byte(fc | FC_EXC_BIT);
      push_random($urandom_range(4, 2) + 1);
      seal_crc();
    end else if (kind < 76) begin
      append_byte(cur_addr);
      push_random(5);
      seal_crc();
    end else if (kind < 82) begin
      cmd = 1'b0;
      append_byte(cur_addr);
      append_byte(FC_READ);
      push_random(3);
      seal_crc();
    end else if (kind < 90) begin
      append_byte(cur_addr);
      append_byte(fc);
      push_random($urandom_range(5, 0));
      if ($urandom_range(3) == 0) frame_q.pop_back();
    end else begin
      push_random($urandom_range(12, 1));
    end
    send_frame(cmd, ereg, eval);
  endtask

  // receiver: random stalls, one long hold-off to fill the block up
  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 31);
        @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned still;
    still = 0;
    stalled_cycles = 0;
    while (still < STALL_LIMIT) begin
      @(posedge clk);
      if (in_valid === 1'b1 && in_ready === 1'b0) stalled_cycles++;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        still = 0;
      end else begin
        still++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    quiet         = 1'b0;
    hold_go       = 1'b0;
    cur_addr      = SLAVE_ADDR_RST;
    bytes_sent    = 0;
    frames_sent   = 0;
    settings_used = 0;
    addr_plan[0]  = 8'h00;
    addr_plan[1]  = 8'hFF;
    addr_plan[2]  = 8'($urandom_range(254, 1));
    addr_plan[3]  = SLAVE_ADDR_RST;
    addr_plan[4]  = 8'($urandom_range(255));
    addr_plan[5]  = 8'($urandom_range(255));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte frame, max read value, write echo at extremes, exception
    frame_q.delete();
    append_byte(8'hFF);
    send_frame(1'b1, 16'hFFFF, 16'h0000);
    frame_q.delete();
    append_byte(cur_addr);
    append_byte(FC_READ);
    append_byte(READ_DATA_BYTES);
    append_byte(8'hFF);
    append_byte(8'hFF);
    seal_crc();
    send_frame(1'b0, 16'h0000, 16'hFFFF);
    frame_q.delete();
    append_byte(cur_addr);
    append_byte(FC_WRITE);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'hFF);
    seal_crc();
    send_frame(1'b1, 16'h0000, 16'hFFFF);
    frame_q.delete();
    append_byte(cur_addr);
    append_byte(FC_READ | FC_EXC_BIT);
    append_byte(8'hFF);
    append_byte(8'h00);
    append_byte(8'h00);
    seal_crc();
    send_frame(1'b0, 16'hFFFF, 16'h0000);
    drain();

    foreach (addr_plan[p]) begin
      set_slave_addr(addr_plan[p]);
      quiet = (p == 2);
      if (p == 1) random_frame(270 + $urandom_range(30));
      if (p == 3) begin
        hold_go = 1'b1;
        repeat (8) begin
          frame_q.delete();
          push_random(1);
          send_frame(1'($urandom_range(1, 0)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)));
        end
      end
      while (bytes_sent < PHASE_BYTES * (p + 1) + 23) random_frame(0);
      drain();
    end

    $display("checked %0d replies from %0d frames, %0d bytes, %0d slave address settings",
             checked, frames_sent, bytes_sent, settings_used);
    $display("status codes hit (bit per code): %b, input stalled %0d cycles",
             seen, stalled_cycles);
    if (mismatches == 0 && due_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
